FILE: sv/pump_status_frame_receiver_unit_macros.svh
// Assertion macros used by the receiver top file.
`ifndef PUMP_STATUS_FRAME_RECEIVER_UNIT_MACROS_SVH
`define PUMP_STATUS_FRAME_RECEIVER_UNIT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define PSFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must never be seen outside reset.
`define PSFR_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: sv/psfr_pkg.sv
package psfr_pkg;

  localparam int unsigned MaxFrame = 32;
  localparam int unsigned CntW     = 6;
  localparam int unsigned LenW     = 9;

  localparam logic [7:0] SyncByte      = 8'h02;
  localparam logic [7:0] StartReset    = 8'h10;
  localparam logic [CntW-1:0] HdrBytes = CntW'(6);
  localparam logic [LenW-1:0] OvhBytes = LenW'(10);

  // Configuration register indexes.
  localparam logic [2:0] CfgStart    = 3'd0;
  localparam logic [2:0] CfgMaster   = 3'd1;
  localparam logic [2:0] CfgStatus   = 3'd2;
  localparam logic [2:0] CfgSpeedSub = 3'd3;
  localparam logic [2:0] CfgPowerSub = 3'd4;

  typedef enum logic [2:0] {
    StRpm       = 3'd0,
    StWatts     = 3'd1,
    StBadSum    = 3'd2,
    StWrongDest = 3'd3,
    StUnknown   = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] master_address;
    logic [7:0] status_command;
    logic [7:0] speed_subcommand;
    logic [7:0] power_subcommand;
  } judge_cfg_t;

  typedef struct packed {
    logic [7:0]  dest;
    logic [7:0]  command;
    logic [7:0]  subcommand;
    logic [7:0]  length;
    logic [7:0]  payload_low;
    logic [7:0]  payload_high;
    logic [15:0] running_sum;
    logic [15:0] received_sum;
  } frame_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] value;
  } result_t;

endpackage

FILE: sv/pump_status_frame_receiver_unit.sv
// Channel   Direction  Handshake              Payload
// input     in         in_valid_i/in_stall_o  rx_byte_i
// result    out        out_valid_o/out_stall_i frame_status_o, report_value_o
// config    in         cfg_we_i               cfg_index_i, cfg_data_i
//
// One byte is taken every cycle while in_stall_o is low; the frame state updates at
// the edge that takes it. The result of the last trailer byte is registered and
// shows on the output in the cycle after it. The only stall comes from the result
// register: while a result is held and out_stall_i is high, in_stall_o is high.
// Reset clears the hunt and restores the configuration registers to their defaults.
module pump_status_frame_receiver_unit
  import psfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  frame_status_o,
  output logic [15:0] report_value_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

`include "pump_status_frame_receiver_unit_macros.svh"

  logic       [7:0] start_q, start_d;
  judge_cfg_t       cfg_q, cfg_d;
  logic             accept;
  logic             done;
  frame_t           frame;
  result_t          judged;
  result_t          result;
  logic             reject_nonzero;
  logic             rpm_unscaled;

  always_comb begin
    start_d = start_q;
    cfg_d   = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgStart:    start_d                = cfg_data_i;
        CfgMaster:   cfg_d.master_address   = cfg_data_i;
        CfgStatus:   cfg_d.status_command   = cfg_data_i;
        CfgSpeedSub: cfg_d.speed_subcommand = cfg_data_i;
        CfgPowerSub: cfg_d.power_subcommand = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= StartReset;
      cfg_q   <= '0;
    end else begin
      start_q <= start_d;
      cfg_q   <= cfg_d;
    end
  end

  assign accept = in_valid_i & ~in_stall_o;

  psfr_framer u_framer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .rx_byte_i    (rx_byte_i),
    .start_byte_i (start_q),
    .done_o       (done),
    .frame_o      (frame)
  );

  psfr_judge u_judge (
    .frame_i  (frame),
    .cfg_i    (cfg_q),
    .result_o (judged)
  );

  psfr_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .load_i      (done),
    .result_i    (judged),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result)
  );

  assign frame_status_o = result.status;
  assign report_value_o = result.value;

  assign reject_nonzero = (frame_status_o == StBadSum || frame_status_o == StWrongDest ||
                           frame_status_o == StUnknown) && (report_value_o != 16'h0000);
  assign rpm_unscaled   = (frame_status_o == StRpm) && (report_value_o[15:14] != 2'b00);

  `PSFR_ASSERT(a_result_follows_request, $rose(out_valid_o) |-> $past(accept), "orphan result")
  `PSFR_NEVER(a_reject_zero_value, out_valid_o && reject_nonzero, "reject carries a value")
  `PSFR_NEVER(a_rpm_scaled, out_valid_o && rpm_unscaled, "rpm value not divided by four")

endmodule

FILE: sv/psfr_framer.sv
module psfr_framer
  import psfr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] rx_byte_i,
  input  logic [7:0] start_byte_i,
  output logic       done_o,
  output frame_t     frame_o
);

  logic [CntW-1:0] cnt_q, cnt_d;
  frame_t          frm_q, frm_d;
  logic [7:0]      sum_hi_q, sum_hi_d;

  logic [CntW:0]   count;
  logic [7:0]      len_eff;
  logic [LenW-1:0] sum_end;
  logic [LenW-1:0] frame_len;
  logic [LenW-1:0] idx_ext;

  always_comb begin
    cnt_d    = cnt_q;
    frm_d    = frm_q;
    sum_hi_d = sum_hi_q;
    done_o   = 1'b0;
    count    = {1'b0, cnt_q} + (CntW+1)'(1);
    len_eff  = (cnt_q == CntW'(5)) ? rx_byte_i : frm_q.length;
    sum_end  = LenW'(len_eff) + LenW'(HdrBytes);
    frame_len = LenW'(len_eff) + OvhBytes;
    idx_ext  = LenW'(cnt_q);
    if (accept_i) begin
      if (cnt_q == '0) begin
        if (rx_byte_i == start_byte_i) begin
          frm_d.running_sum = {8'h00, rx_byte_i};
          cnt_d = CntW'(1);
        end
      end else if (cnt_q == CntW'(1) && rx_byte_i != SyncByte) begin
        // A repeated start byte restarts the frame at that byte.
        if (rx_byte_i == start_byte_i) begin
          frm_d.running_sum = {8'h00, rx_byte_i};
          cnt_d = CntW'(1);
        end else begin
          cnt_d = '0;
        end
      end else if (cnt_q >= CntW'(MaxFrame)) begin
        cnt_d = '0;
      end else begin
        case (cnt_q)
          CntW'(2): frm_d.dest         = rx_byte_i;
          CntW'(3): frm_d.command      = rx_byte_i;
          CntW'(4): frm_d.subcommand   = rx_byte_i;
          CntW'(5): frm_d.length       = rx_byte_i;
          CntW'(6): frm_d.payload_low  = rx_byte_i;
          CntW'(7): frm_d.payload_high = rx_byte_i;
          default: ;
        endcase
        if (cnt_q < HdrBytes || idx_ext < sum_end) begin
          frm_d.running_sum = frm_q.running_sum + {8'h00, rx_byte_i};
        end else if (idx_ext == sum_end) begin
          sum_hi_d = rx_byte_i;
        end else if (idx_ext == sum_end + LenW'(1)) begin
          frm_d.received_sum = {sum_hi_q, rx_byte_i};
        end
        cnt_d = count[CntW-1:0];
        if (count >= (CntW+1)'(8)) begin
          if (frame_len > LenW'(MaxFrame)) begin
            cnt_d = '0;
          end else if (LenW'(count) >= frame_len) begin
            done_o = 1'b1;
            cnt_d  = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      frm_q    <= '0;
      sum_hi_q <= '0;
    end else begin
      cnt_q    <= cnt_d;
      frm_q    <= frm_d;
      sum_hi_q <= sum_hi_d;
    end
  end

  assign frame_o = frm_q;

endmodule

FILE: sv/psfr_judge.sv
module psfr_judge
  import psfr_pkg::*;
(
  input  frame_t     frame_i,
  input  judge_cfg_t cfg_i,
  output result_t    result_o
);

  logic [15:0] word;
  logic        is_status;

  assign word      = {frame_i.payload_high, frame_i.payload_low};
  assign is_status = (frame_i.command == cfg_i.status_command) && (frame_i.length >= 8'd2);

  // Checksum is checked first, then the destination, then the content.
  always_comb begin
    result_o.value = '0;
    if (frame_i.running_sum != frame_i.received_sum) begin
      result_o.status = StBadSum;
    end else if (frame_i.dest != cfg_i.master_address) begin
      result_o.status = StWrongDest;
    end else if (is_status && frame_i.subcommand == cfg_i.speed_subcommand) begin
      result_o.status = StRpm;
      result_o.value  = {2'b00, word[15:2]};
    end else if (is_status && frame_i.subcommand == cfg_i.power_subcommand) begin
      result_o.status = StWatts;
      result_o.value  = word;
    end else begin
      result_o.status = StUnknown;
    end
  end

endmodule

FILE: sv/psfr_out_reg.sv
module psfr_out_reg
  import psfr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  logic    load_i,
  input  result_t result_i,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t res_q, res_d;

  // A held result only blocks new requests while the consumer stalls it.
  assign in_stall_o = valid_q & out_stall_i;

  always_comb begin
    valid_d = valid_q & out_stall_i;
    res_d   = res_q;
    if (in_valid_i && !in_stall_o && load_i) begin
      valid_d = 1'b1;
      res_d   = result_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = valid_q;
  assign result_o    = res_q;

endmodule

FILE: dv/psfr_report_checker.sv
`timescale 1ns / 100ps
module psfr_report_checker
  import psfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  frame_status_i,
  input  logic [15:0] report_value_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  output int          fail_count_o,
  output int          reports_waiting_o,
  output int          reports_checked_o,
  output logic        frame_open_o
);

  judge_cfg_t  judge_cfg;
  logic [7:0]  start_sel;

  logic [5:0]  byte_cnt;
  logic [15:0] run_sum;
  logic [15:0] rx_sum;
  logic [7:0]  dest_q;
  logic [7:0]  cmd_q;
  logic [7:0]  sub_q;
  logic [7:0]  len_q;
  logic [7:0]  pay_lo;
  logic [7:0]  pay_hi;
  logic [7:0]  sum_hi;

  result_t     awaited_reports[$];

  // Checksum errors mask everything else, then the address, then the content.
  function automatic result_t judge_frame();
    result_t     r;
    logic [15:0] word;
    word    = {pay_hi, pay_lo};
    r.value = '0;
    if (run_sum != rx_sum) begin
      r.status = StBadSum;
    end else if (dest_q != judge_cfg.master_address) begin
      r.status = StWrongDest;
    end else if (cmd_q == judge_cfg.status_command && sub_q == judge_cfg.speed_subcommand &&
                 len_q >= 8'd2) begin
      r.status = StRpm;
      r.value  = word >> 2;
    end else if (cmd_q == judge_cfg.status_command && sub_q == judge_cfg.power_subcommand &&
                 len_q >= 8'd2) begin
      r.status = StWatts;
      r.value  = word;
    end else begin
      r.status = StUnknown;
    end
    return r;
  endfunction

  // Advances the frame state by one received byte; returns 1 when a frame completes.
  function automatic bit decode_rx_byte(input logic [7:0] b, output result_t r);
    int idx;
    int count;
    int flen;
    idx      = int'(byte_cnt);
    r.status = StUnknown;
    r.value  = '0;
    if (idx == 0) begin
      if (b == start_sel) begin
        run_sum  = {8'h00, b};
        byte_cnt = 6'd1;
      end
      return 1'b0;
    end
    if (idx == 1 && b != SyncByte) begin
      // A second start byte restarts the frame at that byte.
      if (b == start_sel) begin
        run_sum  = {8'h00, b};
        byte_cnt = 6'd1;
      end else begin
        byte_cnt = '0;
      end
      return 1'b0;
    end
    if (idx >= int'(MaxFrame)) begin
      byte_cnt = '0;
      return 1'b0;
    end
    case (idx)
      2: dest_q = b;
      3: cmd_q  = b;
      4: sub_q  = b;
      5: len_q  = b;
      6: pay_lo = b;
      7: pay_hi = b;
      default: ;
    endcase
    if (idx < int'(HdrBytes) + int'(len_q)) begin
      run_sum = run_sum + {8'h00, b};
    end else if (idx == int'(HdrBytes) + int'(len_q)) begin
      sum_hi = b;
    end else if (idx == int'(HdrBytes) + int'(len_q) + 1) begin
      rx_sum = {sum_hi, b};
    end
    count    = idx + 1;
    byte_cnt = 6'(count);
    if (count >= 8) begin
      flen = int'(OvhBytes) + int'(len_q);
      if (flen > int'(MaxFrame)) begin
        byte_cnt = '0;
        return 1'b0;
      end
      if (count >= flen) begin
        r        = judge_frame();
        byte_cnt = '0;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch_proc
    result_t want;
    result_t made;
    if (!rst_ni) begin
      judge_cfg         = '0;
      start_sel         = StartReset;
      byte_cnt          = '0;
      run_sum           = '0;
      rx_sum            = '0;
      dest_q            = '0;
      cmd_q             = '0;
      sub_q             = '0;
      len_q             = '0;
      pay_lo            = '0;
      pay_hi            = '0;
      sum_hi            = '0;
      fail_count_o      = 0;
      reports_checked_o = 0;
      awaited_reports.delete();
    end else begin
      // A result taken at this edge belongs to a byte taken at an earlier edge.
      if (out_valid_i && !out_stall_i) begin
        if (awaited_reports.size() == 0) begin
          $error("frame report with no request waiting: status %0d, value %0d",
                 frame_status_i, report_value_i);
          fail_count_o++;
        end else begin
          want = awaited_reports.pop_front();
          reports_checked_o++;
          if (frame_status_i !== want.status) begin
            $error("frame_status: expected %0d, got %0d", want.status, frame_status_i);
            fail_count_o++;
          end
          if (report_value_i !== want.value) begin
            $error("report_value: expected %0d, got %0d", want.value, report_value_i);
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgStart:    start_sel                  = cfg_data_i;
          CfgMaster:   judge_cfg.master_address   = cfg_data_i;
          CfgStatus:   judge_cfg.status_command   = cfg_data_i;
          CfgSpeedSub: judge_cfg.speed_subcommand = cfg_data_i;
          CfgPowerSub: judge_cfg.power_subcommand = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (decode_rx_byte(rx_byte_i, made)) begin
          awaited_reports.push_back(made);
        end
      end
    end
    reports_waiting_o = awaited_reports.size();
    frame_open_o      = (byte_cnt != '0);
  end

endmodule

FILE: dv/pump_status_frame_receiver_unit_test.sv
`timescale 1ns / 100ps
module pump_status_frame_receiver_unit_test;
  import psfr_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int HoldCycles = 300;
  localparam int PhaseBytes = 190;
  localparam int NumPhases  = 8;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  logic [7:0]  rx_byte   = 8'h00;
  logic        out_stall = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = CfgStart;
  logic [7:0]  cfg_data  = 8'h00;

  logic        in_stall;
  logic        out_valid;
  logic [2:0]  frame_status;
  logic [15:0] report_value;

  int          fail_count;
  int          reports_waiting;
  int          reports_checked;
  logic        frame_open;

  int          idle_pct      = 0;
  int          stall_pct     = 0;
  int          hold_requests = 0;
  int          hold_served   = 0;
  int          hold_left     = 0;
  int          cycles        = 0;
  int          bytes_sent    = 0;

  logic [7:0]  start_val  = StartReset;
  logic [7:0]  master_val = 8'h00;
  logic [7:0]  status_val = 8'h00;
  logic [7:0]  speed_val  = 8'h00;
  logic [7:0]  power_val  = 8'h00;
  logic [7:0]  frame_bytes[$];

  pump_status_frame_receiver_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .frame_status_o (frame_status),
    .report_value_o (report_value),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  psfr_report_checker u_report_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .rx_byte_i         (rx_byte),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .frame_status_i    (frame_status),
    .report_value_i    (report_value),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .fail_count_o      (fail_count),
    .reports_waiting_o (reports_waiting),
    .reports_checked_o (reports_checked),
    .frame_open_o      (frame_open)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result back-pressure; a hold-off keeps stall high for a long counted stretch.
  always @(posedge clk_i) begin
    if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left   <= HoldCycles;
      out_stall   <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(negedge clk_i); while (in_stall);
    @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_frame_bytes();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
  endtask

  task automatic trim_frame(input int keep);
    while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
  endtask

  // The checksum covers everything from the start byte up to the last payload byte.
  task automatic build_frame(input logic [7:0] dest, input logic [7:0] cmd,
                             input logic [7:0] sub, input logic [7:0] len,
                             input logic [15:0] word, input logic [15:0] sum_flip);
    logic [15:0] sum;
    logic [7:0]  b;
    frame_bytes = {start_val, SyncByte, dest, cmd, sub, len};
    for (int i = 0; i < int'(len); i++) begin
      b = (i == 0) ? word[7:0] : (i == 1) ? word[15:8] : 8'($urandom);
      frame_bytes.push_back(b);
    end
    sum = '0;
    foreach (frame_bytes[i]) sum = sum + {8'h00, frame_bytes[i]};
    sum = sum ^ sum_flip;
    frame_bytes.push_back(sum[15:8]);
    frame_bytes.push_back(sum[7:0]);
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(8'($urandom));
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (reports_waiting != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Runs any half-received frame to its end so that registers change between frames.
  task automatic settle_block();
    logic [7:0] filler;
    filler = start_val + 8'd1;
    if (filler == SyncByte) filler = SyncByte + 8'd1;
    wait_quiet();
    while (frame_open) begin
      send_byte(filler);
      wait_quiet();
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
  endtask

  // Runs with the reset values, where both subcommands match and rpm must win.
  task automatic run_directed();
    frame_bytes = {8'h00, 8'hFF, 8'h7F};
    send_frame_bytes();
    build_frame(8'h00, 8'h00, 8'h00, 8'd2, 16'hFFFF, 16'h0000);
    send_frame_bytes();
    build_frame(8'h00, 8'h00, 8'h00, 8'd22, 16'h0000, 16'h0000);
    send_frame_bytes();
    build_frame(8'h00, 8'h00, 8'h00, 8'd2, 16'($urandom), 16'hFFFF);
    send_frame_bytes();
    build_frame(8'hFF, 8'h00, 8'h00, 8'd2, 16'($urandom), 16'h0000);
    send_frame_bytes();
    build_frame(8'hFF, 8'h00, 8'h00, 8'd2, 16'($urandom), 16'h8000);
    send_frame_bytes();
    build_frame(8'h00, 8'h00, 8'h00, 8'd1, 16'($urandom), 16'h0000);
    send_frame_bytes();
    build_frame(8'h00, 8'h00, 8'h00, 8'd0, 16'($urandom), 16'h0000);
    send_frame_bytes();
    build_frame(8'h00, 8'hFF, 8'h00, 8'd2, 16'($urandom), 16'h0000);
    send_frame_bytes();
    build_frame(8'h00, 8'h00, 8'h00, 8'd23, 16'($urandom), 16'h0000);
    trim_frame(8);
    send_frame_bytes();
    build_frame(8'h00, 8'h00, 8'h00, 8'd255, 16'($urandom), 16'h0000);
    trim_frame(8);
    send_frame_bytes();
    build_frame(8'h00, 8'h00, 8'h00, 8'd2, 16'($urandom), 16'h0000);
    frame_bytes.push_front(start_val);
    send_frame_bytes();
    build_frame(8'h00, 8'h00, 8'h00, 8'd3, 16'($urandom), 16'h0000);
    frame_bytes.push_front(8'h03);
    frame_bytes.push_front(start_val);
    send_frame_bytes();
  endtask

  // Mostly well-formed frames with random content, some cut short, some line noise.
  task automatic send_random_sequence();
    int          kind;
    int          pick;
    logic [7:0]  dest;
    logic [7:0]  cmd;
    logic [7:0]  sub;
    logic [7:0]  len;
    logic [15:0] flip;
    kind = $urandom_range(0, 99);
    dest = ($urandom_range(0, 9) < 8) ? master_val : 8'($urandom);
    cmd  = ($urandom_range(0, 9) < 8) ? status_val : 8'($urandom);
    pick = $urandom_range(0, 2);
    sub  = (pick == 0) ? speed_val : (pick == 1) ? power_val : 8'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 6) len = 8'($urandom_range(0, 3));
    else if (pick < 9) len = 8'($urandom_range(4, 22));
    else len = 8'($urandom_range(23, 255));
    flip = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535)) : 16'h0000;
    build_frame(dest, cmd, sub, len, 16'($urandom), flip);
    if (int'(len) + int'(OvhBytes) > int'(MaxFrame)) trim_frame(8 + $urandom_range(0, 3));
    if (kind >= 70 && kind < 80) begin
      trim_frame($urandom_range(1, frame_bytes.size() - 1));
    end else if (kind >= 80 && kind < 90) begin
      frame_bytes = {};
      repeat ($urandom_range(1, 8)) begin
        frame_bytes.push_back(($urandom_range(0, 3) == 0) ? start_val : 8'($urandom));
      end
    end else if (kind >= 90) begin
      frame_bytes.push_front(start_val);
    end
    send_frame_bytes();
  endtask

  initial begin : stimulus
    int  phase_base;
    bit  paused;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int p = 0; p < NumPhases; p++) begin
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 79; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 79; end
        default: begin idle_pct = 36; stall_pct <= 36; end
      endcase
      if (p == 0) begin
        run_directed();
      end else begin
        settle_block();
        case (p)
          1: begin
            start_val = 8'hFF; master_val = 8'hFF; status_val = 8'hFF;
            speed_val = 8'h00; power_val  = 8'hFF;
          end
          2: begin
            start_val = 8'h00; master_val = 8'h00; status_val = 8'h00;
            speed_val = 8'hFF; power_val  = 8'h00;
          end
          default: begin
            start_val  = (p == 3) ? SyncByte : 8'($urandom);
            master_val = 8'($urandom);
            status_val = 8'($urandom);
            speed_val  = 8'($urandom);
            power_val  = (p == 5) ? speed_val : 8'($urandom);
          end
        endcase
        write_reg(CfgStart, start_val);
        write_reg(CfgMaster, master_val);
        write_reg(CfgStatus, status_val);
        write_reg(CfgSpeedSub, speed_val);
        write_reg(CfgPowerSub, power_val);
        cfg_we <= 1'b0;
        build_frame(master_val, status_val, power_val, 8'd2, 16'hFFFF, 16'h0000);
        send_frame_bytes();
      end
      // With the sender running flat out, a long hold-off fills the result register.
      if (p % 4 == 0) hold_requests <= hold_requests + 1;
      phase_base = bytes_sent;
      paused     = 1'b0;
      while (bytes_sent - phase_base < PhaseBytes) begin
        if (!paused && bytes_sent - phase_base >= PhaseBytes / 2) begin
          wait_quiet();
          paused = 1'b1;
        end
        send_random_sequence();
      end
    end
    wait_quiet();
    $display("Sent %0d serial bytes under %0d register settings; %0d frame reports compared.",
             bytes_sent, NumPhases, reports_checked);
    $display("Mixes of sender gaps and result stalls included a long hold-off and full drains.");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: pump_status_frame_receiver_unit.f
+incdir+sv
sv/psfr_pkg.sv
sv/psfr_framer.sv
sv/psfr_judge.sv
sv/psfr_out_reg.sv
sv/pump_status_frame_receiver_unit.sv
dv/psfr_report_checker.sv
dv/pump_status_frame_receiver_unit_test.sv
